[hdl/kmp_pkg.sv]
package kmp_pkg;

  localparam int MAX_PATTERN   = 32;
  localparam int POSITION_BITS = 32;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [1:0] KIND_PATTERN = 2'd0;
  localparam logic [1:0] KIND_TEXT    = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic        matched;
    logic [31:0] match_start;
    logic        pattern_overflow;
  } out_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic rd;
    logic cmp;
    logic fb_rd;
    logic fb_use;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk;
    logic retry;
    logic fallback;
  } sts_t;

endpackage

[hdl/kmp_stream_matcher.sv]
// Knuth-Morris-Pratt matcher over a byte stream.
// Each request on the input channel carries a kind and a byte. A pattern byte
// is appended to the pattern store and its failure entry is built on the fly;
// a text byte advances the match along failure links; a clear request empties
// the pattern and resets the match length and text position.
// Every request gives exactly one result on the output channel: a match flag
// with the text position of the occurrence's first byte, or the overflow flag
// when a pattern byte finds the store full.
// Without a table lookup an accepted request passes through the decide and done
// states, and its result is then loaded into the output register. Each compare
// against the pattern adds a read state (one registered read of the pattern and
// failure memories) and a compare state: one compare for the current length and
// one more for every step along the failure links. A full match adds the fallback
// read and fallback use states to fetch the fallback link. Failure walks amortise
// to about two lookups per byte. The block works on one request at a time and
// takes the next request while the previous result still waits in the output register.
// After reset the pattern is empty and the text position is zero; no clearing
// pass is needed. While the receiver stalls, the result holds steady; a
// finished request then waits until the output register is free.
module kmp_stream_matcher import kmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t cmd;
  sts_t st;

  kmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  kmp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

[hdl/kmp_ctrl.sv]
module kmp_ctrl import kmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t st,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_FBRD   = 3'd4;
  localparam logic [2:0] S_FBUSE  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = st.walk ? S_RD : S_DONE;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (st.retry) begin
          state_nxt = S_RD;
        end else if (st.fallback) begin
          state_nxt = S_FBRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FBRD: begin
        cmd.fb_rd = 1'b1;
        state_nxt = S_FBUSE;
      end
      S_FBUSE: begin
        cmd.fb_use = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/kmp_dp.sv]
module kmp_dp import kmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t st,
  output out_t out_data
);

  logic [7:0]               pat_mem [MAX_PATTERN];
  logic [LEN_W-1:0]         fail_mem [MAX_PATTERN];

  logic [1:0]               kind_r;
  logic [7:0]               sym_r;
  logic [LEN_W-1:0]         cur_r;
  logic [LEN_W-1:0]         plen_r;
  logic [LEN_W-1:0]         bplen_r;
  logic [LEN_W-1:0]         mlen_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [7:0]               pat_q_r;
  logic [LEN_W-1:0]         fail_q_r;
  logic                     res_matched_r;
  logic [POSITION_BITS-1:0] res_start_r;
  logic                     res_ovf_r;
  out_t                     out_r;

  logic                     full;
  logic                     hit;
  logic [LEN_W-1:0]         adv;
  logic [LEN_W-1:0]         cur_m1;
  logic [LEN_W-1:0]         plen_m1;
  logic [LEN_W-1:0]         fail_addr;
  logic                     wr_en;
  logic [LEN_W-1:0]         wr_fail;

  assign full    = (plen_r == LEN_W'(MAX_PATTERN));
  assign hit     = (sym_r == pat_q_r);
  assign adv     = cur_r + LEN_W'(hit);
  assign cur_m1  = cur_r - LEN_W'(1);
  assign plen_m1 = plen_r - LEN_W'(1);

  assign fail_addr = cmd.fb_rd ? plen_m1 : cur_m1;

  assign st.walk     = ((kind_r == KIND_PATTERN) && !full && (plen_r != '0)) ||
                       ((kind_r == KIND_TEXT) && (plen_r != '0));
  assign st.retry    = (cur_r != '0) && !hit;
  assign st.fallback = (kind_r == KIND_TEXT) && (adv == plen_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_fail = '0;
    if (cmd.decide && (kind_r == KIND_PATTERN) && !full && (plen_r == '0)) begin
      wr_en = 1'b1;
    end
    if (cmd.cmp && !st.retry && (kind_r == KIND_PATTERN)) begin
      wr_en   = 1'b1;
      wr_fail = adv;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_mem[plen_r[IDX_W-1:0]]  <= sym_r;
      fail_mem[plen_r[IDX_W-1:0]] <= wr_fail;
    end
    if (cmd.rd) begin
      pat_q_r <= pat_mem[cur_r[IDX_W-1:0]];
    end
    if (cmd.rd || cmd.fb_rd) begin
      fail_q_r <= fail_mem[fail_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_data.kind;
      sym_r  <= in_data.symbol;
    end
    if (cmd.decide) begin
      res_matched_r <= 1'b0;
      res_start_r   <= '0;
      res_ovf_r     <= (kind_r == KIND_PATTERN) && full;
      if (kind_r == KIND_TEXT) begin
        cur_r <= (mlen_r >= plen_r) ? '0 : mlen_r;
      end else begin
        cur_r <= bplen_r;
      end
    end
    if (cmd.cmp && st.retry) begin
      cur_r <= fail_q_r;
    end
    if (cmd.cmp && !st.retry && (kind_r == KIND_TEXT) && st.fallback) begin
      res_matched_r <= 1'b1;
      res_start_r   <= pos_r - POSITION_BITS'(plen_m1);
    end
    if (cmd.out_load) begin
      out_r.matched          <= res_matched_r;
      out_r.match_start      <= 32'(res_start_r);
      out_r.pattern_overflow <= res_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      bplen_r <= '0;
      mlen_r  <= '0;
      pos_r   <= '0;
    end else begin
      if (cmd.decide) begin
        if (kind_r == KIND_CLEAR) begin
          plen_r  <= '0;
          bplen_r <= '0;
          mlen_r  <= '0;
          pos_r   <= '0;
        end else if ((kind_r == KIND_PATTERN) && !full && (plen_r == '0)) begin
          plen_r  <= LEN_W'(1);
          bplen_r <= '0;
        end else if ((kind_r == KIND_TEXT) && (plen_r == '0)) begin
          pos_r <= pos_r + POSITION_BITS'(1);
        end
      end
      if (cmd.cmp && !st.retry) begin
        if (kind_r == KIND_PATTERN) begin
          bplen_r <= adv;
          plen_r  <= plen_r + LEN_W'(1);
        end else begin
          mlen_r <= adv;
          pos_r  <= pos_r + POSITION_BITS'(1);
        end
      end
      if (cmd.fb_use) begin
        mlen_r <= fail_q_r;
      end
    end
  end

  assign out_data = out_r;

endmodule

[test/tb_kmp_stream_matcher.sv]
`timescale 1ns / 1ps

module tb_kmp_stream_matcher;
  import kmp_pkg::*;

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  logic [7:0]               pattern_bytes [MAX_PATTERN];
  logic [LEN_W-1:0]         failure_links [MAX_PATTERN];
  logic [LEN_W-1:0]         pattern_len;
  logic [LEN_W-1:0]         build_len;
  logic [LEN_W-1:0]         match_len;
  logic [POSITION_BITS-1:0] text_pos;

  out_t        expected_results [$];
  bit          idle_enabled;
  bit          long_hold_pending;
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned matches_seen;
  int unsigned overflows_seen;
  int unsigned cycle_count;

  kmp_stream_matcher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_matcher();
    pattern_len = '0;
    build_len   = '0;
    match_len   = '0;
    text_pos    = '0;
  endfunction

  function automatic out_t predict_result(in_t req);
    out_t             res;
    logic [LEN_W-1:0] k;
    res = '0;
    case (req.kind)
      KIND_PATTERN: begin
        if (pattern_len >= MAX_PATTERN) begin
          res.pattern_overflow = 1'b1;
        end else begin
          pattern_bytes[pattern_len[IDX_W-1:0]] = req.symbol;
          if (pattern_len == 0) begin
            build_len = '0;
            failure_links[0] = '0;
          end else begin
            k = build_len;
            while (k > 0 && req.symbol != pattern_bytes[k[IDX_W-1:0]]) begin
              k = k - LEN_W'(1);
              k = failure_links[k[IDX_W-1:0]];
            end
            if (req.symbol == pattern_bytes[k[IDX_W-1:0]]) k++;
            build_len = k;
            failure_links[pattern_len[IDX_W-1:0]] = k;
          end
          pattern_len++;
        end
      end
      KIND_TEXT: begin
        if (pattern_len > 0) begin
          k = match_len;
          if (k >= pattern_len) k = '0;
          while (k > 0 && req.symbol != pattern_bytes[k[IDX_W-1:0]]) begin
            k = k - LEN_W'(1);
            k = failure_links[k[IDX_W-1:0]];
          end
          if (req.symbol == pattern_bytes[k[IDX_W-1:0]]) k++;
          if (k == pattern_len) begin
            res.matched = 1'b1;
            res.match_start = 32'(text_pos - POSITION_BITS'(pattern_len - 1));
            k = k - LEN_W'(1);
            k = failure_links[k[IDX_W-1:0]];
          end
          match_len = k;
        end
        text_pos++;
      end
      KIND_CLEAR: clear_matcher();
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_t make_request(logic [1:0] kind, logic [7:0] symbol);
    in_t req;
    req.kind   = kind;
    req.symbol = symbol;
    return req;
  endfunction

  task automatic send_request(input in_t req);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results = {expected_results, predict_result(req)};
    requests_sent++;
  endtask

  task automatic send_text(input logic [7:0] symbol);
    send_request(make_request(KIND_TEXT, symbol));
  endtask

  task automatic send_pattern(input logic [7:0] symbol);
    send_request(make_request(KIND_PATTERN, symbol));
  endtask

  task automatic test_empty_pattern();
    send_text(8'h00);
    send_text(8'hFF);
    send_request(make_request(KIND_RESERVED, 8'hA5));
    send_request(make_request(KIND_CLEAR, 8'h5A));
  endtask

  task automatic test_overlapping_matches();
    send_pattern(8'hFF);
    send_pattern(8'h00);
    send_pattern(8'hFF);
    send_text(8'hFF);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h5A);
    send_text(8'hFF);
    send_pattern(8'h00);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h00);
    send_request(make_request(KIND_RESERVED, 8'hFF));
    send_request(make_request(KIND_CLEAR, 8'h00));
    send_text(8'hFF);
  endtask

  task automatic test_receiver_backpressure();
    send_request(make_request(KIND_CLEAR, 8'h00));
    send_pattern(8'h3C);
    send_pattern(8'h3C);
    long_hold_pending = 1'b1;
    repeat (30) send_text(8'h3C);
  endtask

  task automatic test_random_sessions(input int unsigned target);
    int unsigned done_items;
    int unsigned plen;
    int unsigned tlen;
    int unsigned alpha_n;
    int unsigned i;
    int unsigned r;
    logic [7:0]  alphabet [4];
    logic [7:0]  sym;
    logic [7:0]  session_pattern [$];
    done_items = 0;
    while (done_items < target) begin
      if ($urandom_range(0, 7) != 0) begin
        send_request(make_request(KIND_CLEAR, 8'($urandom_range(0, 255))));
        session_pattern.delete();
        done_items++;
      end
      alpha_n = $urandom_range(2, 4);
      for (i = 0; i < 4; i++) alphabet[2'(i)] = 8'($urandom_range(0, 255));
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (i = 0; i < plen; i++) begin
        sym = alphabet[2'($urandom_range(0, alpha_n - 1))];
        send_pattern(sym);
        if (session_pattern.size() < MAX_PATTERN) session_pattern = {session_pattern, sym};
        done_items++;
      end
      tlen = $urandom_range(10, 60);
      i = 0;
      while (i < tlen) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          foreach (session_pattern[j]) send_text(session_pattern[j]);
          i += session_pattern.size();
          done_items += session_pattern.size();
        end else if (r < 30) begin
          send_text(8'($urandom_range(0, 255)));
          i++;
          done_items++;
        end else if (r < 32) begin
          send_request(make_request(KIND_RESERVED, 8'($urandom_range(0, 255))));
          i++;
        end else if (r < 34) begin
          sym = alphabet[2'($urandom_range(0, alpha_n - 1))];
          send_pattern(sym);
          if (session_pattern.size() < MAX_PATTERN) session_pattern = {session_pattern, sym};
          i++;
          done_items++;
        end else begin
          send_text(alphabet[2'($urandom_range(0, alpha_n - 1))]);
          i++;
          done_items++;
        end
      end
    end
  endtask

  task automatic test_unthrottled_tail();
    idle_enabled = 1'b0;
    test_random_sessions(400);
  endtask

  initial begin : receiver_stall
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, actual %p", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.matched) matches_seen++;
        if (want.pattern_overflow) overflows_seen++;
        if (out_data.matched !== want.matched) begin
          error_count++;
          $display("%0t: matched expected %0b actual %0b",
                   $time, want.matched, out_data.matched);
        end
        if (out_data.match_start !== want.match_start) begin
          error_count++;
          $display("%0t: match_start expected %0d actual %0d",
                   $time, want.match_start, out_data.match_start);
        end
        if (out_data.pattern_overflow !== want.pattern_overflow) begin
          error_count++;
          $display("%0t: pattern_overflow expected %0b actual %0b",
                   $time, want.pattern_overflow, out_data.pattern_overflow);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    idle_enabled = 1'b1;
    long_hold_pending = 1'b0;
    error_count = 0;
    requests_sent = 0;
    results_checked = 0;
    matches_seen = 0;
    overflows_seen = 0;
    clear_matcher();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pattern();
    test_overlapping_matches();
    test_receiver_backpressure();
    test_random_sessions(1500);
    test_unthrottled_tail();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results: %0d matches, %0d overflows.",
             requests_sent, results_checked, matches_seen, overflows_seen);
    $display("Covered empty, overlapping, grown and full patterns, and a long output hold.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[kmp_stream_matcher.f]
hdl/kmp_pkg.sv
hdl/kmp_ctrl.sv
hdl/kmp_dp.sv
hdl/kmp_stream_matcher.sv
test/tb_kmp_stream_matcher.sv
